// ===== sv/brt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brt_pkg - shared types for the triangle raster unit
// Word widths of coordinates, edge values and the blend accumulator, and the
// request and response bundles of the blend divider.
// ----------------------------------------------------------------------------
package brt_pkg;

  localparam int COORD_W = 12;  // vertex coordinate as it arrives
  localparam int PT_W    = 13;  // coordinate difference, clamped box corner
  localparam int EDGE_W  = 27;  // edge function value
  localparam int ACC_W   = 40;  // multiply-accumulate result
  localparam int CH_W    = 8;   // one colour channel

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PT_W-1:0]    pt_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic [CH_W-1:0]           chan_t;

  typedef struct packed {
    logic  start;
    acc_t  num;
    edge_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    chan_t quo;
  } div_rsp_t;

endpackage

// ===== sv/barycentric_triangle_raster_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barycentric_triangle_raster_unit - triangle rasterizer with a frame store
// Read request: the address is formed in S_RADDR, the frame store is read
// in S_RREQ and S_RDATA, and the result is registered in S_OUT. Draw
// request: setup, then one uncovered box pixel per cycle, while a covered
// pixel uses the shared multiply-accumulate unit and the 10-step divider
// three times. One request at a time. Reset clears control state, then a
// clearing pass zeroes the frame store before the first request is taken.
// ----------------------------------------------------------------------------
module barycentric_triangle_raster_unit #(
  parameter int FB_WIDTH  = 64,
  parameter int FB_HEIGHT = 64,
  parameter int COLOR_MAX = 255
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  brt_pkg::coord_t       v0_x,
  input  brt_pkg::coord_t       v0_y,
  input  brt_pkg::coord_t       v1_x,
  input  brt_pkg::coord_t       v1_y,
  input  brt_pkg::coord_t       v2_x,
  input  brt_pkg::coord_t       v2_y,
  input  logic [23:0]           v0_color,
  input  logic [23:0]           v1_color,
  input  logic [23:0]           v2_color,
  input  logic [5:0]            read_col,
  input  logic [5:0]            read_row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            pixel_red,
  output logic [7:0]            pixel_green,
  output logic [7:0]            pixel_blue,
  output logic [12:0]           pixels_written,
  output logic                  degenerate
);
  import brt_pkg::*;

  localparam int  DEPTH  = FB_WIDTH * FB_HEIGHT;
  localparam int  AW     = $clog2(DEPTH);
  localparam pt_t FBW_PT = pt_t'(FB_WIDTH);
  localparam pt_t FBH_PT = pt_t'(FB_HEIGHT);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RADDR, S_RREQ, S_RDATA, S_SETUP, S_PIX, S_COLOR, S_DIV,
    S_OUT
  } state_t;

  state_t state;

  // Captured request.
  coord_t      vx [3];
  coord_t      vy [3];
  logic [23:0] col [3];
  logic [5:0]  rcol, rrow;
  logic        rd_ok;

  // Walk state. Edge i runs between vertices i+1 and i+2.
  pt_t         xmin, ymin, xmax, ymax, x, y;
  edge_t       d;
  edge_t       off [3];
  edge_t       e [3];
  edge_t       rowe [3];
  acc_t        acc;
  logic [2:0]  ev;
  logic [1:0]  ms;
  logic [1:0]  ch;
  logic [AW-1:0] addr, row_addr, clr;
  logic [12:0] count;
  chan_t       cr, cg;
  logic        deg;

  // Result staging.
  chan_t       st_r, st_g, st_b;

  // Edge coefficients.
  pt_t ea [3];
  pt_t eb [3];
  always_comb begin
    ea[0] = pt_t'(vy[1]) - pt_t'(vy[2]);
    eb[0] = pt_t'(vx[2]) - pt_t'(vx[1]);
    ea[1] = pt_t'(vy[2]) - pt_t'(vy[0]);
    eb[1] = pt_t'(vx[0]) - pt_t'(vx[2]);
    ea[2] = pt_t'(vy[0]) - pt_t'(vy[1]);
    eb[2] = pt_t'(vx[1]) - pt_t'(vx[0]);
  end

  // Bounding box of the incoming vertices, clamped to the frame.
  function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (c < m) ? c : m;
  endfunction

  function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (c > m) ? c : m;
  endfunction

  coord_t mnx, mny, mxx, mxy;
  pt_t    xmin_n, ymin_n, xmax_n, ymax_n;
  always_comb begin
    mnx = min3(v0_x, v1_x, v2_x);
    mny = min3(v0_y, v1_y, v2_y);
    mxx = max3(v0_x, v1_x, v2_x);
    mxy = max3(v0_y, v1_y, v2_y);
    xmin_n = (mnx < 0) ? '0 : pt_t'(mnx);
    ymin_n = (mny < 0) ? '0 : pt_t'(mny);
    xmax_n = (pt_t'(mxx) > FBW_PT) ? FBW_PT : pt_t'(mxx);
    ymax_n = (pt_t'(mxy) > FBH_PT) ? FBH_PT : pt_t'(mxy);
  end

  // A zero edge value counts only when the point (-1,-1) lies on the
  // vertex side of that edge.
  function automatic logic edge_ok(edge_t f, edge_t fo, edge_t dd);
    if (f != 0) begin
      return (f > 0) == (dd > 0);
    end
    return (fo != 0) && ((fo > 0) == (dd > 0));
  endfunction

  logic pix_in;
  assign pix_in = edge_ok(e[0], off[0], d) && edge_ok(e[1], off[1], d) &&
                  edge_ok(e[2], off[2], d);

  // Shared multiply-accumulate unit. Setup evaluates the edge function of
  // one edge at one point in four steps: A*px, B*py, xa*yb, -xb*ya.
  logic [1:0] ei;
  logic [1:0] va, vb;
  pt_t        px, py;
  edge_t      op_a;
  pt_t        op_b;
  acc_t       prod, mac_sum;

  always_comb begin
    ei = 2'd0;
    if (ev >= 3'd1 && ev <= 3'd3) begin
      ei = 2'(ev - 3'd1);
    end else if (ev >= 3'd4) begin
      ei = 2'(ev - 3'd4);
    end
    case (ei)
      2'd0:    begin va = 2'd1; vb = 2'd2; end
      2'd1:    begin va = 2'd2; vb = 2'd0; end
      default: begin va = 2'd0; vb = 2'd1; end
    endcase
    if (ev == 3'd0) begin
      px = pt_t'(vx[0]);
      py = pt_t'(vy[0]);
    end else if (ev <= 3'd3) begin
      px = -pt_t'(1);
      py = -pt_t'(1);
    end else begin
      px = xmin;
      py = ymin;
    end

    op_a = '0;
    op_b = '0;
    case (state)
      S_SETUP: begin
        if (ev == 3'd7) begin
          // Start address ymin*FB_WIDTH + xmin.
          op_a = (ms == 2'd0) ? edge_t'(ymin) : edge_t'(xmin);
          op_b = (ms == 2'd0) ? FBW_PT : pt_t'(1);
        end else begin
          case (ms)
            2'd0:    begin op_a = edge_t'(ea[ei]);     op_b = px; end
            2'd1:    begin op_a = edge_t'(eb[ei]);     op_b = py; end
            2'd2:    begin op_a = edge_t'(vx[va]);     op_b = pt_t'(vy[vb]); end
            default: begin op_a = -edge_t'(vx[vb]);    op_b = pt_t'(vy[va]); end
          endcase
        end
      end
      S_RADDR: begin
        op_a = (ms == 2'd0) ? edge_t'({1'b0, rrow}) : edge_t'({1'b0, rcol});
        op_b = (ms == 2'd0) ? FBW_PT : pt_t'(1);
      end
      S_COLOR: begin
        op_a = e[ms];
        case (ch)
          2'd0:    op_b = pt_t'({1'b0, col[ms][23:16]});
          2'd1:    op_b = pt_t'({1'b0, col[ms][15:8]});
          default: op_b = pt_t'({1'b0, col[ms][7:0]});
        endcase
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod    = acc_t'(op_a * op_b);
    mac_sum = ((ms == 2'd0) ? acc_t'(0) : acc) + prod;
  end

  // Blend divider.
  div_req_t div_req;
  div_rsp_t div_rsp;
  assign div_req = '{start: (state == S_COLOR) && (ms == 2'd2), num: mac_sum, den: d};

  brt_div #(.COLOR_MAX(COLOR_MAX)) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Frame store.
  logic          we;
  logic [AW-1:0] waddr;
  logic [23:0]   wdata, rdata;
  logic          pix_done;
  logic          do_adv;

  assign pix_done = (state == S_DIV) && div_rsp.done && (ch == 2'd2);
  assign do_adv   = ((state == S_PIX) && !pix_in) || pix_done;
  assign we       = (state == S_CLEAR) || pix_done;
  assign waddr    = (state == S_CLEAR) ? clr : addr;
  assign wdata    = (state == S_CLEAR) ? 24'd0 : {cr, cg, div_rsp.quo};

  brt_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_frame (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
      ms        <= '0;
      ev        <= '0;
      ch        <= '0;
    end else begin
      // In S_OUT the result register is reloaded below instead.
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            clr <= clr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            vx[0] <= v0_x; vy[0] <= v0_y;
            vx[1] <= v1_x; vy[1] <= v1_y;
            vx[2] <= v2_x; vy[2] <= v2_y;
            col[0] <= v0_color;
            col[1] <= v1_color;
            col[2] <= v2_color;
            rcol  <= read_col;
            rrow  <= read_row;
            rd_ok <= (pt_t'({1'b0, read_col}) < FBW_PT) &&
                     (pt_t'({1'b0, read_row}) < FBH_PT);
            xmin  <= xmin_n;
            ymin  <= ymin_n;
            xmax  <= xmax_n;
            ymax  <= ymax_n;
            st_r  <= '0;
            st_g  <= '0;
            st_b  <= '0;
            deg   <= 1'b0;
            count <= '0;
            ms    <= '0;
            ev    <= '0;
            state <= kind ? S_RADDR : S_SETUP;
          end
        end
        S_RADDR: begin
          acc <= mac_sum;
          if (ms == 2'd1) begin
            addr  <= AW'(mac_sum);
            ms    <= '0;
            state <= S_RREQ;
          end else begin
            ms <= ms + 2'd1;
          end
        end
        S_RREQ: begin
          state <= S_RDATA;
        end
        S_RDATA: begin
          if (rd_ok) begin
            st_r <= rdata[23:16];
            st_g <= rdata[15:8];
            st_b <= rdata[7:0];
          end
          state <= S_OUT;
        end
        S_SETUP: begin
          acc <= mac_sum;
          if ((ev == 3'd7 && ms == 2'd1) || (ev != 3'd7 && ms == 2'd3)) begin
            ms <= '0;
            ev <= ev + 3'd1;
            if (ev == 3'd0) begin
              d <= EDGE_W'(mac_sum);
              if (mac_sum == 0) begin
                // Zero area: nothing is drawn.
                deg   <= 1'b1;
                state <= S_OUT;
              end
            end else if (ev <= 3'd3) begin
              off[ei] <= EDGE_W'(mac_sum);
            end else if (ev <= 3'd6) begin
              e[ei]    <= EDGE_W'(mac_sum);
              rowe[ei] <= EDGE_W'(mac_sum);
            end else begin
              addr     <= AW'(mac_sum);
              row_addr <= AW'(mac_sum);
              x        <= xmin;
              y        <= ymin;
              state    <= (xmin < xmax && ymin < ymax) ? S_PIX : S_OUT;
            end
          end else begin
            ms <= ms + 2'd1;
          end
        end
        S_PIX: begin
          if (pix_in) begin
            ms    <= '0;
            ch    <= '0;
            state <= S_COLOR;
          end
        end
        S_COLOR: begin
          acc <= mac_sum;
          if (ms == 2'd2) begin
            ms    <= '0;
            state <= S_DIV;
          end else begin
            ms <= ms + 2'd1;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            case (ch)
              2'd0: begin
                cr    <= div_rsp.quo;
                ch    <= 2'd1;
                state <= S_COLOR;
              end
              2'd1: begin
                cg    <= div_rsp.quo;
                ch    <= 2'd2;
                state <= S_COLOR;
              end
              default: begin
                count <= count + 13'd1;
              end
            endcase
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            pixel_red      <= st_r;
            pixel_green    <= st_g;
            pixel_blue     <= st_b;
            pixels_written <= count;
            degenerate     <= deg;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Step to the next pixel of the box, row by row.
      if (do_adv) begin
        if (x + pt_t'(1) < xmax) begin
          x     <= x + pt_t'(1);
          addr  <= addr + 1'b1;
          for (int i = 0; i < 3; i++) begin
            e[i] <= e[i] + edge_t'(ea[i]);
          end
          state <= S_PIX;
        end else if (y + pt_t'(1) < ymax) begin
          y        <= y + pt_t'(1);
          x        <= xmin;
          row_addr <= row_addr + AW'(FB_WIDTH);
          addr     <= row_addr + AW'(FB_WIDTH);
          for (int i = 0; i < 3; i++) begin
            rowe[i] <= rowe[i] + edge_t'(eb[i]);
            e[i]    <= rowe[i] + edge_t'(eb[i]);
          end
          state <= S_PIX;
        end else begin
          state <= S_OUT;
        end
      end
    end
  end

endmodule

// ===== sv/brt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brt_ram - generic single write port RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module brt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/brt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brt_div - saturating blend divider
// Restoring division of the colour sum by the doubled area, one quotient bit
// a cycle; a negative quotient gives zero and a large one gives full scale.
// ----------------------------------------------------------------------------
module brt_div #(
  parameter int COLOR_MAX = 255
) (
  input  logic               clk,
  input  logic               rst,
  input  brt_pkg::div_req_t  req,
  output brt_pkg::div_rsp_t  rsp
);
  import brt_pkg::*;

  localparam int QW = 9;

  logic              busy;
  logic              done;
  logic [3:0]        cnt;
  logic [ACC_W-1:0]  rem;
  logic [EDGE_W-1:0] ud;
  logic [QW-1:0]     q;
  logic              sat;

  logic              pos;
  logic [ACC_W-1:0]  un;
  logic [EDGE_W-1:0] udn;
  logic [ACC_W-1:0]  shifted;
  logic              ge;
  chan_t             quo;

  always_comb begin
    pos = (req.num > 0 && req.den > 0) || (req.num < 0 && req.den < 0);
    un  = (req.num < 0) ? ACC_W'(-req.num) : ACC_W'(req.num);
    udn = (req.den < 0) ? EDGE_W'(-req.den) : EDGE_W'(req.den);
    shifted = ACC_W'(ud) << cnt;
    ge = rem >= shifted;
    if (sat || q > QW'(COLOR_MAX)) begin
      quo = CH_W'(COLOR_MAX);
    end else begin
      quo = q[CH_W-1:0];
    end
  end

  assign rsp = '{done: done, quo: quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 4'd9;
        rem  <= pos ? un : '0;
        ud   <= udn;
        q    <= '0;
        sat  <= 1'b0;
      end else if (busy) begin
        if (cnt == 4'd9) begin
          // Quotient of 512 or more saturates.
          sat <= ge;
        end else if (ge) begin
          rem    <= rem - shifted;
          q[cnt] <= 1'b1;
        end
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 4'd1;
        end
      end
    end
  end

endmodule
